// ----- hdl/page_free_list_allocator_core_macros.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef PAGE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every clk edge outside reset.
`define PFLA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pfla_pkg.sv -----
// Package: field widths, codes and result types of the page allocator.
`default_nettype none
package pfla_pkg;

	localparam int MAX_PAGES_DEF = 1024;

	localparam int PAGE_W  = 10;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 11;
	localparam int FREE_W  = 10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	typedef struct packed {
		logic [PAGE_W-1:0]  given_page;
		logic [STAT_W-1:0]  status;
		logic [TOTAL_W-1:0] pages_in_use_total;
		logic [FREE_W-1:0]  free_pages;
	} rslt_t;

	typedef struct packed {
		logic  valid;
		rslt_t data;
	} rslt_push_t;

endpackage
`default_nettype wire

// ----- hdl/pfla_req_if.sv -----
// Request channel interface: operation and page number with valid/ready.
`default_nettype none
interface pfla_req_if;
	import pfla_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [PAGE_W-1:0] page_number;

	modport source (output valid, output operation, output page_number, input ready);
	modport sink   (input valid, input operation, input page_number, output ready);
endinterface
`default_nettype wire

// ----- hdl/pfla_rsp_if.sv -----
// Result channel interface: page, status and counts with valid/ready.
`default_nettype none
interface pfla_rsp_if;
	import pfla_pkg::*;

	logic               valid;
	logic               ready;
	logic [PAGE_W-1:0]  given_page;
	logic [STAT_W-1:0]  status;
	logic [TOTAL_W-1:0] pages_in_use_total;
	logic [FREE_W-1:0]  free_pages;

	modport source (output valid, output given_page, output status,
		output pages_in_use_total, output free_pages, input ready);
	modport sink   (input valid, input given_page, input status,
		input pages_in_use_total, input free_pages, output ready);
endinterface
`default_nettype wire

// ----- hdl/pfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/pfla_out_fifo.sv -----
// Two-entry result queue between the engine and the result channel.
`default_nettype none
`include "page_free_list_allocator_core_macros.svh"
module pfla_out_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pfla_pkg::rslt_push_t push,
	output logic                      room,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pfla_pkg::rslt_t           out_data
);
	import pfla_pkg::*;

	localparam logic [1:0] CNT_FULL = 2'd2;

	rslt_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (cnt_q != CNT_FULL);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push.valid) wr_ptr_q <= ~wr_ptr_q;
			if (pop)        rd_ptr_q <= ~rd_ptr_q;
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`PFLA_ASSERT_NOW(a_fifo_no_overflow, push.valid, cnt_q != CNT_FULL, "result queue overflow")
	`PFLA_ASSERT_NOW(a_fifo_cnt_range, 1'b1, cnt_q <= CNT_FULL, "result queue count out of range")
	`PFLA_ASSERT_NEXT(a_fifo_push_shows, push.valid && cnt_q == 2'd0, out_valid,
		"pushed result not presented")
endmodule
`default_nettype wire

// ----- hdl/pfla_engine.sv -----
// Allocator engine: free-list head, totals and link store read-modify-write.
`default_nettype none
`include "page_free_list_allocator_core_macros.svh"
module pfla_engine #(
	parameter int MAX_PAGES = pfla_pkg::MAX_PAGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        in_op,
	input  wire logic [pfla_pkg::PAGE_W-1:0] in_page,
	input  wire logic                        room,
	output pfla_pkg::rslt_push_t             push
);
	import pfla_pkg::*;

	localparam int PW = $clog2(MAX_PAGES);
	localparam int HW = PW + 1;
	localparam int CW = (HW > PAGE_W) ? HW : PAGE_W;

	typedef enum logic {S_IDLE, S_POP} state_t;

	state_t        state_q, state_d;
	logic [HW-1:0] head_q, head_d;
	logic [HW-1:0] total_q, total_d;
	logic [PW-1:0] cnt_q, cnt_d;

	logic          ram_we, ram_re;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [HW-1:0] ram_wdata, ram_rdata;

	logic          accept;
	logic          list_empty;
	logic [CW-1:0] pg_ext;
	logic          pg_bad;

	pfla_ram #(.WIDTH(HW), .DEPTH(MAX_PAGES)) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready   = (state_q == S_IDLE) && room;
	assign accept     = in_valid && in_ready;
	assign list_empty = (head_q >= HW'(MAX_PAGES));
	assign pg_ext     = CW'(in_page);
	assign pg_bad     = (pg_ext == '0) || (pg_ext >= CW'(total_q)) ||
		(pg_ext >= CW'(MAX_PAGES));

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		total_d   = total_q;
		cnt_d     = cnt_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q[PW-1:0];
		ram_waddr = PW'(pg_ext);
		ram_wdata = head_q;
		push      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_ALLOC) begin
						if (!list_empty) begin
							// pop: link of the head comes back next cycle
							ram_re  = 1'b1;
							state_d = S_POP;
						end else if (total_q < HW'(MAX_PAGES)) begin
							push.valid           = 1'b1;
							push.data.given_page = PAGE_W'(total_q);
							push.data.status     = STAT_OK;
							total_d              = total_q + 1'b1;
						end else begin
							push.valid       = 1'b1;
							push.data.status = STAT_FULL;
						end
					end else begin
						push.valid = 1'b1;
						if (pg_bad) begin
							push.data.status = STAT_INVALID;
						end else begin
							push.data.status = STAT_OK;
							ram_we           = 1'b1;
							head_d           = HW'(pg_ext);
							if (cnt_q < PW'(MAX_PAGES - 1)) cnt_d = cnt_q + 1'b1;
						end
					end
				end
			end
			S_POP: begin
				head_d               = ram_rdata;
				if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
				push.valid           = 1'b1;
				push.data.given_page = PAGE_W'(head_q);
				push.data.status     = STAT_OK;
				state_d              = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		push.data.pages_in_use_total = TOTAL_W'(total_d);
		push.data.free_pages         = FREE_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= HW'(MAX_PAGES);
			total_q <= HW'(1);
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			total_q <= total_d;
			cnt_q   <= cnt_d;
		end
	end

	`PFLA_ASSERT_NEXT(a_pop_one_cycle, state_q == S_POP, state_q == S_IDLE,
		"pop state held longer than one cycle")
	`PFLA_ASSERT_NOW(a_pop_pushes, state_q == S_POP, push.valid && !in_ready,
		"pop cycle without result or with request taken")
	`PFLA_ASSERT_NOW(a_ram_one_port, ram_we, !ram_re, "link store read and write together")
	`PFLA_ASSERT_NOW(a_head_range, 1'b1, head_q <= HW'(MAX_PAGES), "free head out of range")
endmodule
`default_nettype wire

// ----- hdl/page_free_list_allocator_core.sv -----
// Top level of the page allocator: engine with link store and result queue.
//
//  channel  modport  payload                                         transfer
//  -------  -------  ----------------------------------------------  -----------------
//  req      sink     operation, page_number                          valid & ready
//  rsp      source   given_page, status, pages_in_use_total,         valid & ready
//                    free_pages
//
// An allocate served from the free list goes through the pop state: the link store
// read at the head returns in the next cycle and becomes the new head.
// Allocate by extension, full, and free (valid or not) push their result from the idle state.
// Reset empties free list and queue, sets the total to 1 and the free count to 0 at once;
// the link store is not cleared. Results go to a two-entry queue, so a request is taken
// while one result waits; req.ready drops while a pop is in progress or the queue is full.
`default_nettype none
module page_free_list_allocator_core #(
	parameter int MAX_PAGES = pfla_pkg::MAX_PAGES_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pfla_req_if.sink   req,
	pfla_rsp_if.source rsp
);
	import pfla_pkg::*;

	rslt_push_t push;
	rslt_t      out_data;
	logic       room;

	pfla_engine #(.MAX_PAGES(MAX_PAGES)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_op    (req.operation),
		.in_page  (req.page_number),
		.room     (room),
		.push     (push)
	);

	pfla_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign rsp.given_page         = out_data.given_page;
	assign rsp.status             = out_data.status;
	assign rsp.pages_in_use_total = out_data.pages_in_use_total;
	assign rsp.free_pages         = out_data.free_pages;
endmodule
`default_nettype wire
